// File: rtl/ring_deque_stack_queue_macros.svh
// assertion macros for the ring deque checker
`ifndef RING_DEQUE_STACK_QUEUE_MACROS_SVH
`define RING_DEQUE_STACK_QUEUE_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define RDSQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define RDSQ_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/rdsq_pkg.sv
// shared constants, codes and types of the ring deque
package rdsq_pkg;

  localparam int DEPTH_DEF      = 256;
  localparam int WORD_WIDTH_DEF = 32;
  localparam int CFG_W          = 9;
  localparam int CFG_AW         = 1;
  localparam int OCC_W          = 9;
  localparam int REQ_W          = 3;
  localparam int IDX_W          = 8;
  localparam int ST_W           = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH   = 3'd0,
    REQ_POP    = 3'd1,
    REQ_DEQ    = 3'd2,
    REQ_TOP    = 3'd3,
    REQ_BOTTOM = 3'd4,
    REQ_GET    = 3'd5,
    REQ_SET    = 3'd6,
    REQ_CLEAR  = 3'd7
  } req_e_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [CFG_AW-1:0] {
    REG_CAPACITY  = 1'b0,
    REG_OVERWRITE = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    status_t              status;
    logic                 dropped;
    logic [OCC_W-1:0]     occupancy;
  } res_t;

endpackage

// File: rtl/ring_deque_stack_queue.sv
// ring deque top level: config registers, word store, sequencer, output register
//
//  channel | dir | handshake          | payload
//  s_*     | in  | s_tvalid/s_tready  | tuser req_type, tdata write_data, slot_index
//  m_*     | out | m_tvalid/m_tready  | tuser status, dropped; tdata read_data, occupancy
//  cfg_*   | in  | cfg_we             | cfg_addr register, cfg_wdata value
//
// an item goes through accept, one store access with pointer update, then result
// one ram access per item; a new item is taken only once the last result leaves
// after rst the whole store is zero filled with s_tready low
// the output register holds a result while m_tready is low; the next item is
// accepted meanwhile and its result waits in the sequencer
module ring_deque_stack_queue
  import rdsq_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int WORD_WIDTH = WORD_WIDTH_DEF,
  localparam int IN_TDW    = ((WORD_WIDTH + IDX_W + 7) / 8) * 8,
  localparam int OUT_TDW   = ((WORD_WIDTH + OCC_W + 7) / 8) * 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [IN_TDW-1:0]  s_tdata,   // write_data, slot_index
  input  logic [REQ_W-1:0]   s_tuser,   // req_type
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [OUT_TDW-1:0] m_tdata,   // read_data, occupancy
  output logic [2:0]         m_tuser,   // status, dropped
  input  logic               cfg_we,
  input  logic [CFG_AW-1:0]  cfg_addr,
  input  logic [CFG_W-1:0]   cfg_wdata
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = PW + 1;
  localparam int XW = (CW > CFG_W) ? CW : CFG_W;

  function automatic logic [CW-1:0] eff_cap(input logic [CFG_W-1:0] v);
    logic [XW-1:0] x;
    x = XW'(v);
    if (x == '0) begin
      x = XW'(1);
    end else if (x > XW'(DEPTH)) begin
      x = XW'(DEPTH);
    end
    return CW'(x);
  endfunction

  logic [CW-1:0]         cap;
  logic                  overwrite;
  logic                  res_valid, res_ready;
  res_t                  res;
  logic [WORD_WIDTH-1:0] res_data;
  logic                  ram_we;
  logic [PW-1:0]         ram_waddr, ram_raddr;
  logic [WORD_WIDTH-1:0] ram_wdata, ram_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      cap       <= eff_cap(CFG_W'(256));
      overwrite <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_CAPACITY:  cap       <= eff_cap(cfg_wdata);
        REG_OVERWRITE: overwrite <= cfg_wdata[0];
      endcase
    end
  end

  rdsq_ram #(
    .WIDTH (WORD_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  rdsq_ctrl #(
    .DEPTH      (DEPTH),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cap        (cap),
    .overwrite  (overwrite),
    .req_valid  (s_tvalid),
    .req_ready  (s_tready),
    .req_type   (s_tuser),
    .write_data (s_tdata[WORD_WIDTH-1:0]),
    .slot_index (s_tdata[WORD_WIDTH+IDX_W-1:WORD_WIDTH]),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .res_data   (res_data),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata)
  );

  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_tdata <= OUT_TDW'({res.occupancy, res_data});
      m_tuser <= {res.dropped, res.status};
    end
  end

endmodule

// File: rtl/rdsq_ram.sv
// generic single-port-write, single-port-read ram with registered read
module rdsq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/rdsq_ctrl.sv
// request sequencer: pointers, empty flag, ram access and zero fill
module rdsq_ctrl
  import rdsq_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int WORD_WIDTH = WORD_WIDTH_DEF,
  localparam int PW        = $clog2(DEPTH),
  localparam int CW        = PW + 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [CW-1:0]         cap,
  input  logic                  overwrite,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  logic [REQ_W-1:0]      req_type,
  input  logic [WORD_WIDTH-1:0] write_data,
  input  logic [IDX_W-1:0]      slot_index,
  output logic                  res_valid,
  input  logic                  res_ready,
  output res_t                  res,
  output logic [WORD_WIDTH-1:0] res_data,
  output logic                  ram_we,
  output logic [PW-1:0]         ram_waddr,
  output logic [WORD_WIDTH-1:0] ram_wdata,
  output logic [PW-1:0]         ram_raddr,
  input  logic [WORD_WIDTH-1:0] ram_rdata
);

  localparam int SW = ((CW > IDX_W) ? CW : IDX_W) + 1;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_CALC  = 4'b0100,
    S_RESP  = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [PW-1:0] head, head_next, head_c;
  logic [PW-1:0] tail, tail_next, tail_c;
  logic          empty, empty_next, empty_c;
  logic [PW-1:0] clr_cnt;

  req_e_t                req_q;
  logic [WORD_WIDTH-1:0] data_q;
  logic [IDX_W-1:0]      idx_q;
  status_t               st_q, st_c;
  logic                  drop_q, drop_c;
  logic                  rdok_q, rdok_c;
  logic [PW-1:0]         raddr_q, raddr_c;
  logic                  we_c;
  logic [PW-1:0]         waddr_c;

  logic [CW-1:0] head_x, tail_x, size, head_inc, tail_inc;
  logic [PW-1:0] head_wrap, nx;
  logic          bad, full;
  logic [SW-1:0] sum, idx_w;
  logic [PW-1:0] pos;
  logic          idx_ge_size, idx_ge_cap;

  // pointer arithmetic on the current registers
  always_comb begin
    head_x    = CW'(head);
    tail_x    = CW'(tail);
    bad       = (head_x >= cap) || (!empty && tail_x >= cap);
    if (empty) begin
      size = '0;
    end else if (tail_x >= head_x) begin
      size = CW'(tail_x - head_x + CW'(1));
    end else begin
      size = CW'(cap - (head_x - tail_x) + CW'(1));
    end
    tail_inc  = tail_x + CW'(1);
    nx        = (tail_inc >= cap) ? '0 : PW'(tail_inc);
    head_inc  = head_x + CW'(1);
    head_wrap = (head_inc >= cap) ? '0 : PW'(head_inc);
    full      = !empty && (nx == head);
    sum       = SW'(head) + SW'(idx_q);
    pos       = (sum >= SW'(cap)) ? PW'(sum - SW'(cap)) : PW'(sum);
    idx_w     = SW'(idx_q);
    idx_ge_size = idx_w >= SW'(size);
    idx_ge_cap  = idx_w >= SW'(cap);
  end

  // request decode
  always_comb begin
    head_c  = head;
    tail_c  = tail;
    empty_c = empty;
    st_c    = ST_OK;
    drop_c  = 1'b0;
    rdok_c  = 1'b0;
    we_c    = 1'b0;
    waddr_c = nx;
    raddr_c = head;
    if (req_q == REQ_CLEAR) begin
      head_c  = '0;
      tail_c  = '0;
      empty_c = 1'b1;
    end else if (bad) begin
      st_c = ST_RANGE;
    end else begin
      unique case (req_q)
        REQ_PUSH: begin
          if (empty) begin
            tail_c  = head;
            waddr_c = head;
            we_c    = 1'b1;
            empty_c = 1'b0;
          end else if (full && !overwrite) begin
            st_c = ST_FULL;
          end else begin
            if (full) begin
              head_c = head_wrap;
              drop_c = 1'b1;
            end
            tail_c  = nx;
            waddr_c = nx;
            we_c    = 1'b1;
          end
        end
        REQ_POP: begin
          if (empty) begin
            st_c = ST_EMPTY;
          end else begin
            raddr_c = tail;
            rdok_c  = 1'b1;
            if (tail == head) begin
              empty_c = 1'b1;
            end else begin
              tail_c = (tail == '0) ? PW'(cap - CW'(1)) : PW'(tail - PW'(1));
            end
          end
        end
        REQ_DEQ: begin
          if (empty) begin
            st_c = ST_EMPTY;
          end else begin
            raddr_c = head;
            rdok_c  = 1'b1;
            if (tail == head) begin
              empty_c = 1'b1;
            end else begin
              head_c = head_wrap;
            end
          end
        end
        REQ_TOP: begin
          if (empty) begin
            st_c = ST_EMPTY;
          end else begin
            raddr_c = tail;
            rdok_c  = 1'b1;
          end
        end
        REQ_BOTTOM: begin
          if (empty) begin
            st_c = ST_EMPTY;
          end else begin
            raddr_c = head;
            rdok_c  = 1'b1;
          end
        end
        REQ_GET: begin
          if (idx_ge_size) begin
            st_c = ST_EMPTY;
          end else begin
            raddr_c = pos;
            rdok_c  = 1'b1;
          end
        end
        REQ_SET: begin
          if (idx_ge_cap) begin
            st_c = ST_RANGE;
          end else begin
            waddr_c = pos;
            we_c    = 1'b1;
            if (empty || idx_ge_size) begin
              tail_c  = pos;
              empty_c = 1'b0;
            end
          end
        end
        REQ_CLEAR: begin
          head_c = head;
        end
      endcase
    end
  end

  always_comb begin
    state_next = state;
    head_next  = head;
    tail_next  = tail;
    empty_next = empty;
    unique case (state)
      S_CLEAR: begin
        if (clr_cnt == PW'(DEPTH - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid) state_next = S_CALC;
      end
      S_CALC: begin
        head_next  = head_c;
        tail_next  = tail_c;
        empty_next = empty_c;
        state_next = S_RESP;
      end
      S_RESP: begin
        if (res_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
      head    <= '0;
      tail    <= '0;
      empty   <= 1'b1;
    end else begin
      state <= state_next;
      head  <= head_next;
      tail  <= tail_next;
      empty <= empty_next;
      if (state == S_CLEAR) clr_cnt <= clr_cnt + PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_q <= REQ_CLEAR;
    end else if (req_valid && req_ready) begin
      req_q <= req_e_t'(req_type);
    end
    if (req_valid && req_ready) begin
      data_q <= write_data;
      idx_q  <= slot_index;
    end
    if (state == S_CALC) begin
      st_q    <= st_c;
      drop_q  <= drop_c;
      rdok_q  <= rdok_c;
      raddr_q <= raddr_c;
    end
  end

  assign req_ready = (state == S_IDLE);
  assign res_valid = (state == S_RESP);

  // store access: zero fill after reset, then one access per request
  assign ram_we    = (state == S_CLEAR) || ((state == S_CALC) && we_c);
  assign ram_waddr = (state == S_CLEAR) ? clr_cnt : waddr_c;
  assign ram_wdata = (state == S_CLEAR) ? '0 : data_q;
  assign ram_raddr = (state == S_CALC) ? raddr_c : raddr_q;

  // status and drop from S_CALC decode, occupancy from new pointers
  assign res.status    = st_q;
  assign res.dropped   = drop_q;
  assign res.occupancy = bad ? '0 : OCC_W'(size);
  assign res_data      = rdok_q ? ram_rdata : '0;

endmodule

// File: rtl/rdsq_checker.sv
// port-level checks of the ring deque, bound to the top level
`include "ring_deque_stack_queue_macros.svh"

module rdsq_checker
  import rdsq_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int WORD_WIDTH = WORD_WIDTH_DEF,
  localparam int OUT_TDW   = ((WORD_WIDTH + OCC_W + 7) / 8) * 8
) (
  input logic               clk,
  input logic               rst,
  input logic               s_tvalid,
  input logic               s_tready,
  input logic               m_tvalid,
  input logic               m_tready,
  input logic [OUT_TDW-1:0] m_tdata,
  input logic [2:0]         m_tuser
);

  `RDSQ_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")
  `RDSQ_ASSERT_IMP(a_fail_clean, m_tvalid && (m_tuser[1:0] != ST_OK), (m_tdata[WORD_WIDTH-1:0] == '0) && !m_tuser[2], "failed request carries data or drop")
  `RDSQ_ASSERT_IMP(a_drop_occ, m_tvalid && m_tuser[2], m_tdata[WORD_WIDTH+OCC_W-1:WORD_WIDTH] != '0, "drop reported with empty store")
  `RDSQ_ASSERT_IMP(a_occ_max, m_tvalid, m_tdata[WORD_WIDTH+OCC_W-1:WORD_WIDTH] <= DEPTH, "occupancy above depth")
  `RDSQ_ASSERT_NXT(a_one_item, s_tvalid && s_tready, !s_tready, "second item taken while one is in work")

endmodule

bind ring_deque_stack_queue rdsq_checker #(
  .DEPTH      (DEPTH),
  .WORD_WIDTH (WORD_WIDTH)
) u_rdsq_checker (.*);
